### src/ple_pkg.sv
// ----------------------------------------------------------------------------
// Positional list engine package
// Shared codes, widths and the per-cycle command that the cell row sees.
// ----------------------------------------------------------------------------
`default_nettype none

package ple_pkg;

	localparam int unsigned DATA_W = 32;
	localparam int unsigned POS_W  = 8;
	localparam int unsigned OP_W   = 2;
	localparam int unsigned STAT_W = 2;
	localparam int unsigned LEN_W  = 7;

	// leaves OR-ed together in the first level of the read tree
	localparam int unsigned GROUP_SIZE = 8;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_READ   = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK      = 2'd0,
		ST_INVALID = 2'd1,
		ST_FULL    = 2'd2,
		ST_RSVD    = 2'd3
	} status_t;

	// command broadcast to every cell of the row
	typedef struct packed {
		logic                     ins;
		logic                     del;
		logic [POS_W-1:0]         slot;
		logic signed [DATA_W-1:0] value;
	} cell_cmd_t;

endpackage

`default_nettype wire

### src/ple_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one list request item.
// ----------------------------------------------------------------------------
`default_nettype none

interface ple_req_if;
	logic                             valid;
	logic                             ready;
	logic [ple_pkg::OP_W-1:0]         op;
	logic [ple_pkg::POS_W-1:0]        position;
	logic signed [ple_pkg::DATA_W-1:0] value;

	modport source (output valid, output op, output position, output value, input ready);
	modport sink (input valid, input op, input position, input value, output ready);
endinterface

`default_nettype wire

### src/ple_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one result item per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface ple_rsp_if;
	logic                             valid;
	logic                             ready;
	logic [ple_pkg::STAT_W-1:0]       status;
	logic [ple_pkg::LEN_W-1:0]        length;
	logic signed [ple_pkg::DATA_W-1:0] read_value;

	modport source (output valid, output status, output length, output read_value,
		input ready);
	modport sink (input valid, input status, input length, input read_value,
		output ready);
endinterface

`default_nettype wire

### src/ple_cell.sv
// ----------------------------------------------------------------------------
// List cell
// Holds one entry; takes from its lower neighbor on insert, from its upper
// neighbor on delete, and offers its entry when it sits at the request slot.
// ----------------------------------------------------------------------------
`default_nettype none

module ple_cell #(
	parameter int INDEX = 0
) (
	input  wire                                  clk,
	input  wire ple_pkg::cell_cmd_t              cmd,
	input  wire logic signed [ple_pkg::DATA_W-1:0] lower,
	input  wire logic signed [ple_pkg::DATA_W-1:0] upper,
	output logic signed [ple_pkg::DATA_W-1:0]    data,
	output logic signed [ple_pkg::DATA_W-1:0]    hit_data
);

	localparam logic [ple_pkg::POS_W-1:0] MY_IDX = ple_pkg::POS_W'(INDEX);

	logic signed [ple_pkg::DATA_W-1:0] data_q;
	logic                              at_slot;
	logic                              past_slot;

	assign at_slot   = (MY_IDX == cmd.slot);
	assign past_slot = (MY_IDX > cmd.slot);

	// shift or load the entry
	always_ff @(posedge clk) begin
		if (cmd.ins && past_slot) begin
			data_q <= lower;
		end else if (cmd.ins && at_slot) begin
			data_q <= cmd.value;
		end else if (cmd.del && (past_slot || at_slot)) begin
			data_q <= upper;
		end
	end

	assign data     = data_q;
	assign hit_data = at_slot ? data_q : '0;

endmodule

`default_nettype wire

### src/ple_reduce.sv
// ----------------------------------------------------------------------------
// Read tree
// Two-level OR of the cells' slot outputs; the group level is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module ple_reduce #(
	parameter int N = 64
) (
	input  wire                                    clk,
	input  wire                                    capture,
	input  wire logic signed [ple_pkg::DATA_W-1:0] leaves [N],
	output logic signed [ple_pkg::DATA_W-1:0]      result
);

	localparam int G  = ple_pkg::GROUP_SIZE;
	localparam int NG = (N + G - 1) / G;

	logic signed [ple_pkg::DATA_W-1:0] grp_d  [NG];
	logic signed [ple_pkg::DATA_W-1:0] grp_s1 [NG];

	// OR each group of leaves
	for (genvar g = 0; g < NG; g++) begin : g_grp
		always_comb begin
			grp_d[g] = '0;
			for (int k = 0; k < G; k++) begin
				if (g * G + k < N) begin
					grp_d[g] = grp_d[g] | leaves[g * G + k];
				end
			end
		end

		always_ff @(posedge clk) begin
			if (capture) begin
				grp_s1[g] <= grp_d[g];
			end
		end
	end

	// OR the registered groups
	always_comb begin
		result = '0;
		for (int g = 0; g < NG; g++) begin
			result = result | grp_s1[g];
		end
	end

endmodule

`default_nettype wire

### src/positional_list_engine_core.sv
// ----------------------------------------------------------------------------
// Positional list engine
// Ordered list of signed 32-bit entries with insert, delete and read at a
// 1-based position.
// ----------------------------------------------------------------------------
// The list lives in a row of CAPACITY cells; on an accepted request every cell
// compares its index with the position and, in that same edge, shifts up,
// shifts down or loads the new value. Each request returns one item with the
// status, the length after the request and the entry read or removed. One
// request is handled at a time: on acceptance the read tree registers its group
// level, the result is then loaded into the output register, and a new
// request is taken once the result has been accepted. Entries above the
// current length hold stale data and are never reported.
`default_nettype none

module positional_list_engine_core #(
	parameter int CAPACITY = 64
) (
	input  wire       clk,
	input  wire       arst_n,
	ple_req_if.sink   req,
	ple_rsp_if.source rsp
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = ((CNT_W > ple_pkg::POS_W) ? CNT_W : ple_pkg::POS_W) + 1;
	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

	logic [CNT_W-1:0] count_q;
	logic             s1_valid_q;
	logic             out_valid_q;
	logic             rd_s1;
	logic [ple_pkg::STAT_W-1:0] status_s1;

	logic [ple_pkg::STAT_W-1:0]        status_q;
	logic [ple_pkg::LEN_W-1:0]         length_q;
	logic signed [ple_pkg::DATA_W-1:0] read_value_q;

	logic                 req_fire;
	logic                 rsp_fire;
	logic [CMP_W-1:0]     pos_w;
	logic [CMP_W-1:0]     cnt_w;
	logic                 pos_nz;
	logic                 ins_ok_pos;
	logic                 acc_ok_pos;
	logic                 full;
	ple_pkg::op_t         op;
	ple_pkg::status_t     status_d;
	logic                 do_ins;
	logic                 do_del;
	logic                 do_rd;
	ple_pkg::cell_cmd_t   cmd;
	logic [CNT_W+ple_pkg::LEN_W-1:0] count_ext;

	logic signed [ple_pkg::DATA_W-1:0] cell_data [CAPACITY];
	logic signed [ple_pkg::DATA_W-1:0] cell_hit  [CAPACITY];
	logic signed [ple_pkg::DATA_W-1:0] tree_out;

	assign req.ready = !s1_valid_q && !out_valid_q;
	assign req_fire  = req.valid && req.ready;
	assign rsp_fire  = out_valid_q && rsp.ready;

	// check the request against the current length
	always_comb begin
		op         = ple_pkg::op_t'(req.op);
		pos_w      = CMP_W'(req.position);
		cnt_w      = CMP_W'(count_q);
		pos_nz     = (req.position != '0);
		ins_ok_pos = pos_nz && (pos_w <= cnt_w + CMP_W'(1));
		acc_ok_pos = pos_nz && (pos_w <= cnt_w);
		full       = (count_q == CAP_CNT);
		status_d   = ple_pkg::ST_INVALID;
		do_ins     = 1'b0;
		do_del     = 1'b0;
		do_rd      = 1'b0;
		case (op)
			ple_pkg::OP_INSERT: begin
				if (!ins_ok_pos) begin
					status_d = ple_pkg::ST_INVALID;
				end else if (full) begin
					status_d = ple_pkg::ST_FULL;
				end else begin
					status_d = ple_pkg::ST_OK;
					do_ins   = 1'b1;
				end
			end
			ple_pkg::OP_DELETE: begin
				if (acc_ok_pos) begin
					status_d = ple_pkg::ST_OK;
					do_del   = 1'b1;
					do_rd    = 1'b1;
				end
			end
			ple_pkg::OP_READ: begin
				if (acc_ok_pos) begin
					status_d = ple_pkg::ST_OK;
					do_rd    = 1'b1;
				end
			end
			default: begin
				status_d = ple_pkg::ST_INVALID;
			end
		endcase
	end

	// broadcast the command to the row
	always_comb begin
		cmd.ins   = req_fire && do_ins;
		cmd.del   = req_fire && do_del;
		cmd.slot  = req.position - ple_pkg::POS_W'(1);
		cmd.value = req.value;
	end

	// row of cells
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [ple_pkg::DATA_W-1:0] lower;
		logic signed [ple_pkg::DATA_W-1:0] upper;

		if (i == 0) begin : g_first
			assign lower = req.value;
		end else begin : g_mid_lo
			assign lower = cell_data[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign upper = cell_data[i];
		end else begin : g_mid_hi
			assign upper = cell_data[i+1];
		end

		ple_cell #(
			.INDEX(i)
		) u_cell (
			.clk      (clk),
			.cmd      (cmd),
			.lower    (lower),
			.upper    (upper),
			.data     (cell_data[i]),
			.hit_data (cell_hit[i])
		);
	end

	// gather the entry at the slot
	ple_reduce #(
		.N(CAPACITY)
	) u_reduce (
		.clk     (clk),
		.capture (req_fire),
		.leaves  (cell_hit),
		.result  (tree_out)
	);

	// advance the length and the control stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (req_fire && do_ins) begin
				count_q <= count_q + CNT_W'(1);
			end else if (req_fire && do_del) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (req_fire) begin
				s1_valid_q <= 1'b1;
			end else if (s1_valid_q) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_valid_q) begin
				out_valid_q <= 1'b1;
			end else if (rsp_fire) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// hold the request's status while the tree settles
	always_ff @(posedge clk) begin
		if (req_fire) begin
			status_s1 <= status_d;
			rd_s1     <= do_rd;
		end
	end

	assign count_ext = {{ple_pkg::LEN_W{1'b0}}, count_q};

	// load the result register
	always_ff @(posedge clk) begin
		if (s1_valid_q) begin
			status_q     <= status_s1;
			length_q     <= count_ext[ple_pkg::LEN_W-1:0];
			read_value_q <= rd_s1 ? tree_out : '0;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.status     = status_q;
	assign rsp.length     = length_q;
	assign rsp.read_value = read_value_q;

endmodule

`default_nettype wire

### sim/positional_list_engine_core_tb.sv
// ----------------------------------------------------------------------------
// Positional list engine testbench
// Drives list requests with bursty valid and a stalling response side. A
// mirror of the list predicts each result, and every response item is
// compared field by field in arrival order.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_list_engine_core_tb;
	import ple_pkg::*;

	localparam int LIST_DEPTH = 64;

	// traffic mixes for the random part
	localparam int MIX_GROW     = 0;
	localparam int MIX_BALANCED = 1;
	localparam int MIX_SHRINK   = 2;

	typedef struct {
		status_t                  status;
		logic [LEN_W-1:0]         length;
		logic signed [DATA_W-1:0] read_value;
	} list_result_t;

	// mirror of the list contents and the results still owed by the block
	class list_mirror;
		logic signed [DATA_W-1:0] cells [LIST_DEPTH];
		int unsigned              count;
		list_result_t             pending [$];
		int unsigned              errors;

		function new();
			count  = 0;
			errors = 0;
		endfunction

		function void note_request(op_t op, logic [POS_W-1:0] pos,
				logic signed [DATA_W-1:0] val);
			list_result_t res;
			int unsigned  p;
			int unsigned  i;
			p = 32'(pos);
			res.status     = ST_OK;
			res.read_value = '0;
			case (op)
			OP_INSERT: begin
				// position check first, full check second
				if (p == 0 || p > count + 1) begin
					res.status = ST_INVALID;
				end else if (count >= LIST_DEPTH) begin
					res.status = ST_FULL;
				end else begin
					for (i = count; i > p - 1; i--)
						cells[i] = cells[i-1];
					cells[p-1] = val;
					count++;
				end
			end
			OP_DELETE: begin
				if (p == 0 || p > count) begin
					res.status = ST_INVALID;
				end else begin
					res.read_value = cells[p-1];
					for (i = p - 1; i + 1 < count; i++)
						cells[i] = cells[i+1];
					count--;
				end
			end
			OP_READ: begin
				if (p == 0 || p > count)
					res.status = ST_INVALID;
				else
					res.read_value = cells[p-1];
			end
			default: begin
				res.status = ST_INVALID;
			end
			endcase
			res.length = LEN_W'(count);
			pending.push_back(res);
		endfunction

		function void check_result(logic [STAT_W-1:0] status, logic [LEN_W-1:0] length,
				logic signed [DATA_W-1:0] read_value);
			list_result_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result item, status %0d length %0d value %0d",
					$time, status, length, read_value);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (status !== want.status) begin
				$display("%0t: status mismatch, expected %0d, actual %0d",
					$time, want.status, status);
				errors++;
			end
			if (length !== want.length) begin
				$display("%0t: length mismatch, expected %0d, actual %0d",
					$time, want.length, length);
				errors++;
			end
			if (read_value !== want.read_value) begin
				$display("%0t: read_value mismatch, expected %0d, actual %0d",
					$time, want.read_value, read_value);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	ple_req_if req_ch();
	ple_rsp_if rsp_ch();

	positional_list_engine_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	list_mirror mirror = new();
	int unsigned burst_left = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// bound the run
	initial begin
		#2000000;
		$display("Test completed with failures");
		$finish;
	end

	// offer one request, opening a new burst after a random gap when due
	task automatic push_request(op_t op, logic [POS_W-1:0] pos,
			logic signed [DATA_W-1:0] val);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
			repeat (gap) begin
				@(negedge clk);
				req_ch.valid <= 1'b0;
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		@(negedge clk);
		req_ch.valid    <= 1'b1;
		req_ch.op       <= op;
		req_ch.position <= pos;
		req_ch.value    <= val;
		do @(posedge clk); while (!req_ch.ready);
		mirror.note_request(op, pos, val);
	endtask

	// build one random request for the given traffic mix
	task automatic push_random(int mix);
		int unsigned roll;
		int unsigned len;
		int unsigned top;
		op_t         op;
		logic [POS_W-1:0] pos;
		logic signed [DATA_W-1:0] val;
		len  = mirror.count;
		roll = $urandom_range(0, 99);
		val  = $urandom();
		if ($urandom_range(0, 19) == 0)
			val = $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
		if (roll < 8) begin
			// noise: any op code at any position
			op  = op_t'($urandom_range(0, 3));
			pos = POS_W'($urandom_range(0, 255));
		end else begin
			roll = $urandom_range(0, 99);
			case (mix)
			MIX_GROW:     op = (roll < 70) ? OP_INSERT : (roll < 85) ? OP_DELETE : OP_READ;
			MIX_SHRINK:   op = (roll < 15) ? OP_INSERT : (roll < 80) ? OP_DELETE : OP_READ;
			default:      op = (roll < 35) ? OP_INSERT : (roll < 65) ? OP_DELETE : OP_READ;
			endcase
			top = (op == OP_INSERT) ? len + 1 : len;
			if (top == 0)
				pos = POS_W'($urandom_range(0, 3));
			else if ($urandom_range(0, 4) == 0)
				pos = $urandom_range(0, 1) ? POS_W'(top) : POS_W'(1);
			else
				pos = POS_W'($urandom_range(1, top));
		end
		push_request(op, pos, val);
	endtask

	// stimulus
	initial begin
		arst_n          = 1'b0;
		req_ch.valid    = 1'b0;
		req_ch.op       = OP_INSERT;
		req_ch.position = '0;
		req_ch.value    = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty list, bad positions, then build a short list and delete from it
		push_request(OP_READ,   8'd1,   32'sd0);
		push_request(OP_DELETE, 8'd1,   32'sd0);
		push_request(OP_INSERT, 8'd0,   32'sd7);
		push_request(OP_INSERT, 8'd2,   32'sd7);
		push_request(OP_INSERT, 8'd1,   32'sh7FFFFFFF);
		push_request(OP_INSERT, 8'd2,   32'sh80000000);
		push_request(OP_INSERT, 8'd1,   32'sd0);
		push_request(OP_INSERT, 8'd2,   -32'sd1);
		push_request(OP_READ,   8'd1,   32'sd0);
		push_request(OP_READ,   8'd4,   32'sd0);
		push_request(OP_READ,   8'd2,   32'sd0);
		push_request(OP_READ,   8'd0,   32'sd0);
		push_request(OP_READ,   8'd5,   32'sd0);
		push_request(OP_READ,   8'd255, 32'sd0);
		push_request(OP_NONE,   8'd1,   -32'sd1);
		push_request(OP_DELETE, 8'd5,   32'sd0);
		push_request(OP_INSERT, 8'd6,   32'sd3);
		push_request(OP_INSERT, 8'd5,   32'sh5A5A5A5A);
		push_request(OP_DELETE, 8'd2,   32'sd0);
		push_request(OP_DELETE, 8'd4,   32'sd0);
		push_request(OP_DELETE, 8'd1,   32'sd0);
		push_request(OP_INSERT, 8'd255, 32'sh0F0F0F0F);

		// random phases: fill to capacity, churn, drain, and again
		repeat (150) push_random(MIX_GROW);
		repeat (150) push_random(MIX_BALANCED);
		repeat (150) push_random(MIX_SHRINK);
		repeat (200) push_random(MIX_GROW);
		repeat (100) push_random(MIX_BALANCED);
		repeat (100) push_random(MIX_SHRINK);

		@(negedge clk);
		req_ch.valid <= 1'b0;

		// drain outstanding results, then allow for the block's latency
		while (mirror.pending.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mirror.errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// response side: changing stall patterns, with two long hold-offs
	initial begin
		int unsigned mode;
		int unsigned span;
		int unsigned cyc;
		rsp_ch.ready = 1'b0;
		cyc = 0;
		forever begin
			mode = $urandom_range(0, 4);
			span = $urandom_range(16, 96);
			repeat (span) begin
				@(negedge clk);
				cyc++;
				if (cyc == 1200 || cyc == 4000) begin
					// hold off long enough for the request side to back up
					rsp_ch.ready <= 1'b0;
					repeat (300) @(negedge clk);
					cyc += 300;
				end else begin
					case (mode)
					0:       rsp_ch.ready <= 1'b1;
					1:       rsp_ch.ready <= cyc[0];
					2:       rsp_ch.ready <= ($urandom_range(0, 1) == 1);
					3:       rsp_ch.ready <= ($urandom_range(0, 3) == 0);
					default: rsp_ch.ready <= ($urandom_range(0, 99) < 85);
					endcase
				end
			end
		end
	end

	// check each accepted result item
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready)
			mirror.check_result(rsp_ch.status, rsp_ch.length, rsp_ch.read_value);
	end

endmodule

`default_nettype wire
